FILE: src/four_pin_steiner_classifier_top_assert.svh
// assertion macros for the four-pin steiner classifier
`ifndef FOUR_PIN_STEINER_CLASSIFIER_TOP_ASSERT_SVH
`define FOUR_PIN_STEINER_CLASSIFIER_TOP_ASSERT_SVH

// same-cycle implication under synchronous reset
`define FPSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpsc assertion failed");

// next-cycle implication under synchronous reset
`define FPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpsc assertion failed");

`endif

FILE: src/fpsc_pkg.sv
// types and constants shared by the four-pin steiner classifier
package fpsc_pkg;

    localparam int COORD_W = 16;
    localparam int NPINS   = 4;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [1:0]         t_pin_idx;

    typedef enum logic [1:0] {
        SHAPE_NONE = 2'd0,
        SHAPE_HIGH = 2'd1,
        SHAPE_LOW  = 2'd2
    } t_shape;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_X_HIGH  = 3'd1,
        KIND_X_LOW   = 3'd2,
        KIND_Y_RIGHT = 3'd3,
        KIND_Y_LEFT  = 3'd4
    } t_kind;

    typedef struct packed {
        t_coord pin_a_x;
        t_coord pin_a_y;
        t_coord pin_b_x;
        t_coord pin_b_y;
        t_coord pin_c_x;
        t_coord pin_c_y;
        t_coord pin_d_x;
        t_coord pin_d_y;
    } t_pins;

    typedef struct packed {
        logic [2:0] tree_kind;
        t_coord     first_steiner_x;
        t_coord     first_steiner_y;
        t_coord     second_steiner_x;
        t_coord     second_steiner_y;
        t_pin_idx   order_first;
        t_pin_idx   order_second;
        t_pin_idx   order_third;
        t_pin_idx   order_fourth;
    } t_result;

    // what one direction lane hands to the merge stage
    typedef struct packed {
        t_shape                    shape;
        t_pin_idx [NPINS-1:0]      order;
        t_coord                    mid_key_1;
        t_coord                    mid_key_2;
        t_coord                    trunk;
    } t_lane;

endpackage

FILE: src/fpsc_lane.sv
// one sort direction: stable rank sort, shape test and trunk coordinate
module fpsc_lane (
    input  logic                               i_clk,
    input  logic                               i_style,
    input  fpsc_pkg::t_coord [fpsc_pkg::NPINS-1:0] i_key,
    input  fpsc_pkg::t_coord [fpsc_pkg::NPINS-1:0] i_cross,
    output fpsc_pkg::t_lane                    o_lane
);
    import fpsc_pkg::*;

    t_pin_idx                rank [NPINS];
    t_coord   [NPINS-1:0]    n_key;
    t_coord   [NPINS-1:0]    n_cross;
    t_pin_idx [NPINS-1:0]    n_ord;
    t_coord   [NPINS-1:0]    r_key;
    t_coord   [NPINS-1:0]    r_cross;
    t_pin_idx [NPINS-1:0]    r_ord;
    t_lane                   n_lane;
    t_lane                   r_lane;
    logic                    strict;
    logic                    above;
    logic                    below;
    t_coord                  mid_lo;
    t_coord                  mid_hi;
    t_coord                  end_lo;
    t_coord                  end_hi;

    // rank of each pin, lower index first on ties
    always_comb begin
        for (int i = 0; i < NPINS; i++) begin
            rank[i] = '0;
            for (int j = 0; j < NPINS; j++) begin
                if (j != i) begin
                    if (i_key[j] < i_key[i] || (i_key[j] == i_key[i] && j < i)) begin
                        rank[i] = rank[i] + t_pin_idx'(1);
                    end
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r < NPINS; r++) begin
            n_key[r]   = '0;
            n_cross[r] = '0;
            n_ord[r]   = '0;
            for (int i = 0; i < NPINS; i++) begin
                if (rank[i] == t_pin_idx'(r)) begin
                    n_key[r]   = i_key[i];
                    n_cross[r] = i_cross[i];
                    n_ord[r]   = t_pin_idx'(i);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_cross <= n_cross;
        r_ord   <= n_ord;
    end

    always_comb begin
        strict = (r_key[0] < r_key[1]) && (r_key[1] < r_key[2]) && (r_key[2] < r_key[3]);
        above  = (r_cross[1] > r_cross[0]) && (r_cross[1] > r_cross[3]) &&
                 (r_cross[2] > r_cross[0]) && (r_cross[2] > r_cross[3]);
        below  = (r_cross[1] < r_cross[0]) && (r_cross[1] < r_cross[3]) &&
                 (r_cross[2] < r_cross[0]) && (r_cross[2] < r_cross[3]);
        mid_lo = (r_cross[1] < r_cross[2]) ? r_cross[1] : r_cross[2];
        mid_hi = (r_cross[1] > r_cross[2]) ? r_cross[1] : r_cross[2];
        end_lo = (r_cross[0] < r_cross[3]) ? r_cross[0] : r_cross[3];
        end_hi = (r_cross[0] > r_cross[3]) ? r_cross[0] : r_cross[3];

        n_lane           = '0;
        n_lane.order     = r_ord;
        n_lane.mid_key_1 = r_key[1];
        n_lane.mid_key_2 = r_key[2];
        priority if (strict && above) begin
            n_lane.shape = SHAPE_HIGH;
            n_lane.trunk = i_style ? end_hi : mid_lo;
        end else if (strict && below) begin
            n_lane.shape = SHAPE_LOW;
            n_lane.trunk = i_style ? end_lo : mid_hi;
        end else begin
            n_lane.shape = SHAPE_NONE;
            n_lane.trunk = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_lane = r_lane;

endmodule

FILE: src/fpsc_merge.sv
// combines the x and y lanes into one result word
module fpsc_merge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  fpsc_pkg::t_lane   i_lane_x,
    input  fpsc_pkg::t_lane   i_lane_y,
    output logic              o_valid,
    output fpsc_pkg::t_result o_result
);
    import fpsc_pkg::*;

    t_result   n_result;
    t_result   r_result;
    logic      r_valid;
    t_pin_idx  [NPINS-1:0] ord;

    always_comb begin
        n_result = '0;
        ord      = i_lane_y.order;
        // y shape overrides x shape
        priority if (i_lane_y.shape != SHAPE_NONE) begin
            n_result.tree_kind        = (i_lane_y.shape == SHAPE_HIGH) ? KIND_Y_RIGHT
                                                                      : KIND_Y_LEFT;
            n_result.first_steiner_x  = i_lane_y.trunk;
            n_result.first_steiner_y  = i_lane_y.mid_key_1;
            n_result.second_steiner_x = i_lane_y.trunk;
            n_result.second_steiner_y = i_lane_y.mid_key_2;
        end else if (i_lane_x.shape != SHAPE_NONE) begin
            n_result.tree_kind        = (i_lane_x.shape == SHAPE_HIGH) ? KIND_X_HIGH
                                                                      : KIND_X_LOW;
            n_result.first_steiner_x  = i_lane_x.mid_key_1;
            n_result.first_steiner_y  = i_lane_x.trunk;
            n_result.second_steiner_x = i_lane_x.mid_key_2;
            n_result.second_steiner_y = i_lane_x.trunk;
            ord                       = i_lane_x.order;
        end else begin
            n_result.tree_kind = KIND_NONE;
        end
        n_result.order_first  = ord[0];
        n_result.order_second = ord[1];
        n_result.order_third  = ord[2];
        n_result.order_fourth = ord[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: src/four_pin_steiner_classifier_top.sv
// top level of the four-pin steiner classifier
// Takes one four-pin net per cycle whenever o_busy is low (o_busy is high only
// during reset and in the cycle after it). The result word is on o_result,
// flagged by o_valid for one cycle, after the net has passed the three register
// stages: the rank sort in each lane, the shape test and trunk pick in each
// lane, and the merge of the x and y lanes. The receiver cannot stall, so a net
// is taken every cycle while o_busy is low, with no backpressure. tree_style is
// written through the cfg channel and must only change while no net is in
// flight.
module four_pin_steiner_classifier_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  fpsc_pkg::t_pins   i_pins,
    output logic              o_valid,
    output fpsc_pkg::t_result o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data
);
    import fpsc_pkg::*;

    `include "four_pin_steiner_classifier_top_assert.svh"

    logic                  r_rdy;
    logic                  r_style;
    logic [1:0]            r_vld;
    logic                  accept;
    t_coord [NPINS-1:0]    x_key;
    t_coord [NPINS-1:0]    y_key;
    t_lane                 lane_x;
    t_lane                 lane_y;

    assign accept = i_start && r_rdy;
    assign x_key  = {i_pins.pin_d_x, i_pins.pin_c_x, i_pins.pin_b_x, i_pins.pin_a_x};
    assign y_key  = {i_pins.pin_d_y, i_pins.pin_c_y, i_pins.pin_b_y, i_pins.pin_a_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy   <= 1'b0;
            r_style <= 1'b0;
            r_vld   <= '0;
        end else begin
            r_rdy <= 1'b1;
            r_vld <= {r_vld[0], accept};
            if (i_cfg_valid && r_rdy) begin
                r_style <= i_cfg_data;
            end
        end
    end

    fpsc_lane u_lane_x (
        .i_clk   (i_clk),
        .i_style (r_style),
        .i_key   (x_key),
        .i_cross (y_key),
        .o_lane  (lane_x)
    );

    fpsc_lane u_lane_y (
        .i_clk   (i_clk),
        .i_style (r_style),
        .i_key   (y_key),
        .i_cross (x_key),
        .o_lane  (lane_y)
    );

    fpsc_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_vld[1]),
        .i_lane_x (lane_x),
        .i_lane_y (lane_y),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    assign o_busy      = !r_rdy;
    assign o_cfg_ready = r_rdy;

    `FPSC_ASSERT_NOW(a_valid_latency, i_clk, i_rst_n, o_valid, $past(accept, 3))
    `FPSC_ASSERT_NEXT(a_pipe_advance, i_clk, i_rst_n, r_vld[1], o_valid)
    `FPSC_ASSERT_NOW(a_kind_range, i_clk, i_rst_n, o_valid, o_result.tree_kind <= KIND_Y_LEFT)
    `FPSC_ASSERT_NOW(a_none_zero, i_clk, i_rst_n,
        o_valid && o_result.tree_kind == KIND_NONE,
        o_result.first_steiner_x == '0 && o_result.second_steiner_y == '0)
    `FPSC_ASSERT_NOW(a_order_perm, i_clk, i_rst_n, o_valid,
        o_result.order_first != o_result.order_second &&
        o_result.order_third != o_result.order_fourth &&
        o_result.order_first != o_result.order_fourth)

endmodule

FILE: test/four_pin_steiner_classifier_top_tb.sv
// testbench for the four-pin steiner classifier top level
`timescale 1ns / 1ps

module four_pin_steiner_classifier_top_tb;
    import fpsc_pkg::*;

    localparam bit STYLE_FLEXIBLE   = 1'b0;
    localparam bit STYLE_UNFLEXIBLE = 1'b1;

    typedef logic [NPINS-1:0][COORD_W-1:0] t_coord_quad;
    typedef t_pin_idx [NPINS-1:0] t_pin_order;

    typedef struct {
        t_pins   pins;
        bit      typed;
        t_result want;
    } t_net_row;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    i_start;
    logic    o_busy;
    t_pins   i_pins;
    logic    o_valid;
    t_result o_result;
    logic    i_cfg_valid;
    logic    o_cfg_ready;
    logic    i_cfg_data;

    t_result  pending_results[$];
    t_net_row net_rows[$];
    bit       style_now;
    int       fail_count = 0;
    int       nets_sent = 0;
    int       directed_sent = 0;
    int       results_checked = 0;
    int       kind_seen[5] = '{0, 0, 0, 0, 0};

    four_pin_steiner_classifier_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_pins      (i_pins),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_pins pins_of(input t_coord ax, ay, bx, by, cx, cy, dx, dy);
        t_pins p;
        p.pin_a_x = ax;
        p.pin_a_y = ay;
        p.pin_b_x = bx;
        p.pin_b_y = by;
        p.pin_c_x = cx;
        p.pin_c_y = cy;
        p.pin_d_x = dx;
        p.pin_d_y = dy;
        return p;
    endfunction

    function automatic void add_row(input t_pins p, input bit typed, input t_result want);
        t_net_row row;
        row.pins  = p;
        row.typed = typed;
        row.want  = want;
        net_rows.insert(net_rows.size(), row);
    endfunction

    function automatic void expect_word(input t_result want);
        pending_results.insert(pending_results.size(), want);
    endfunction

    function automatic t_coord coord_min(input t_coord a, input t_coord b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_coord coord_max(input t_coord a, input t_coord b);
        return (a > b) ? a : b;
    endfunction

    // stable rank sort, lower pin index first on ties
    function automatic t_pin_order rank_sort(input t_coord_quad key);
        t_pin_order ord;
        int rank;
        ord = '0;
        for (int i = 0; i < NPINS; i++) begin
            rank = 0;
            for (int j = 0; j < NPINS; j++) begin
                if (key[j] < key[i] || (key[j] == key[i] && j < i)) rank++;
            end
            ord[rank] = t_pin_idx'(i);
        end
        return ord;
    endfunction

    function automatic t_shape shape_test(input t_coord_quad key, input t_coord_quad cross_key,
                                          input t_pin_order o);
        t_coord c0, c1, c2, c3;
        c0 = cross_key[o[0]];
        c1 = cross_key[o[1]];
        c2 = cross_key[o[2]];
        c3 = cross_key[o[3]];
        if (!(key[o[0]] < key[o[1]] && key[o[1]] < key[o[2]] && key[o[2]] < key[o[3]]))
            return SHAPE_NONE;
        if (c1 > c0 && c1 > c3 && c2 > c0 && c2 > c3) return SHAPE_HIGH;
        if (c1 < c0 && c1 < c3 && c2 < c0 && c2 < c3) return SHAPE_LOW;
        return SHAPE_NONE;
    endfunction

    function automatic t_result steiner_predict(input t_pins p, input bit style);
        t_coord_quad xs, ys;
        t_pin_order  ox, oy, ord;
        t_shape      sx, sy;
        t_kind       kind;
        t_coord      trunk;
        t_result     r;
        xs[0] = p.pin_a_x;
        ys[0] = p.pin_a_y;
        xs[1] = p.pin_b_x;
        ys[1] = p.pin_b_y;
        xs[2] = p.pin_c_x;
        ys[2] = p.pin_c_y;
        xs[3] = p.pin_d_x;
        ys[3] = p.pin_d_y;
        ox = rank_sort(xs);
        oy = rank_sort(ys);
        sx = shape_test(xs, ys, ox);
        sy = shape_test(ys, xs, oy);
        kind = KIND_NONE;
        if (sx == SHAPE_HIGH) kind = KIND_X_HIGH;
        else if (sx == SHAPE_LOW) kind = KIND_X_LOW;
        // y shape wins over x shape
        if (sy == SHAPE_HIGH) kind = KIND_Y_RIGHT;
        else if (sy == SHAPE_LOW) kind = KIND_Y_LEFT;
        r = '0;
        ord = oy;
        case (kind)
            KIND_X_HIGH, KIND_X_LOW: begin
                ord = ox;
                if (style == STYLE_FLEXIBLE)
                    trunk = (kind == KIND_X_HIGH) ? coord_min(ys[ord[1]], ys[ord[2]])
                                                  : coord_max(ys[ord[1]], ys[ord[2]]);
                else
                    trunk = (kind == KIND_X_HIGH) ? coord_max(ys[ord[0]], ys[ord[3]])
                                                  : coord_min(ys[ord[0]], ys[ord[3]]);
                r.first_steiner_x  = xs[ord[1]];
                r.first_steiner_y  = trunk;
                r.second_steiner_x = xs[ord[2]];
                r.second_steiner_y = trunk;
            end
            KIND_Y_RIGHT, KIND_Y_LEFT: begin
                if (style == STYLE_FLEXIBLE)
                    trunk = (kind == KIND_Y_RIGHT) ? coord_min(xs[ord[1]], xs[ord[2]])
                                                   : coord_max(xs[ord[1]], xs[ord[2]]);
                else
                    trunk = (kind == KIND_Y_RIGHT) ? coord_max(xs[ord[0]], xs[ord[3]])
                                                   : coord_min(xs[ord[0]], xs[ord[3]]);
                r.first_steiner_x  = trunk;
                r.first_steiner_y  = ys[ord[1]];
                r.second_steiner_x = trunk;
                r.second_steiner_y = ys[ord[2]];
            end
            default: ;
        endcase
        r.tree_kind    = kind;
        r.order_first  = ord[0];
        r.order_second = ord[1];
        r.order_third  = ord[2];
        r.order_fourth = ord[3];
        return r;
    endfunction

    // mostly shaped nets with random content, some broken, some plain noise
    function automatic t_pins random_net();
        t_coord k[4];
        t_coord q[4];
        t_coord xs[4];
        t_coord ys[4];
        int     perm[4];
        int     pick, maxstep, j, tmp, th, b;
        bit     along_y, middles_high;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            return pins_of(t_coord'($urandom), t_coord'($urandom), t_coord'($urandom),
                           t_coord'($urandom), t_coord'($urandom), t_coord'($urandom),
                           t_coord'($urandom), t_coord'($urandom));
        if (pick < 30)
            return pins_of(t_coord'($urandom_range(0, 3)), t_coord'($urandom_range(0, 3)),
                           t_coord'($urandom_range(0, 3)), t_coord'($urandom_range(0, 3)),
                           t_coord'($urandom_range(0, 3)), t_coord'($urandom_range(0, 3)),
                           t_coord'($urandom_range(0, 3)), t_coord'($urandom_range(0, 3)));
        maxstep = ($urandom_range(0, 1) == 1) ? 16000 : 3;
        k[0] = t_coord'($urandom_range(0, 65535 - 3 * maxstep));
        for (int i = 1; i < 4; i++) k[i] = k[i-1] + t_coord'($urandom_range(1, maxstep));
        middles_high = $urandom_range(0, 1);
        th = $urandom_range(1, 65535);
        for (int i = 0; i < 4; i++) begin
            if ((i == 1 || i == 2) == middles_high) q[i] = t_coord'($urandom_range(th, 65535));
            else q[i] = t_coord'($urandom_range(0, th - 1));
        end
        if ($urandom_range(0, 4) == 0) begin
            b = $urandom_range(0, 2);
            if ($urandom_range(0, 1) == 1) k[b+1] = k[b];
            else q[1] = q[3];
        end
        for (int i = 0; i < 4; i++) perm[i] = i;
        for (int i = 3; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        along_y = $urandom_range(0, 1);
        for (int s = 0; s < 4; s++) begin
            if (along_y) begin
                ys[perm[s]] = k[s];
                xs[perm[s]] = q[s];
            end else begin
                xs[perm[s]] = k[s];
                ys[perm[s]] = q[s];
            end
        end
        return pins_of(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], xs[3], ys[3]);
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    task automatic check_result(input t_result want, input t_result got);
        results_checked++;
        kind_seen[want.tree_kind]++;
        if (got.tree_kind !== want.tree_kind) begin
            $error("tree_kind mismatch: expected %0d, got %0d", want.tree_kind, got.tree_kind);
            fail_count++;
        end
        if (got.first_steiner_x !== want.first_steiner_x) begin
            $error("first_steiner_x mismatch: expected %0d, got %0d",
                   want.first_steiner_x, got.first_steiner_x);
            fail_count++;
        end
        if (got.first_steiner_y !== want.first_steiner_y) begin
            $error("first_steiner_y mismatch: expected %0d, got %0d",
                   want.first_steiner_y, got.first_steiner_y);
            fail_count++;
        end
        if (got.second_steiner_x !== want.second_steiner_x) begin
            $error("second_steiner_x mismatch: expected %0d, got %0d",
                   want.second_steiner_x, got.second_steiner_x);
            fail_count++;
        end
        if (got.second_steiner_y !== want.second_steiner_y) begin
            $error("second_steiner_y mismatch: expected %0d, got %0d",
                   want.second_steiner_y, got.second_steiner_y);
            fail_count++;
        end
        if (got.order_first !== want.order_first) begin
            $error("order_first mismatch: expected %0d, got %0d",
                   want.order_first, got.order_first);
            fail_count++;
        end
        if (got.order_second !== want.order_second) begin
            $error("order_second mismatch: expected %0d, got %0d",
                   want.order_second, got.order_second);
            fail_count++;
        end
        if (got.order_third !== want.order_third) begin
            $error("order_third mismatch: expected %0d, got %0d",
                   want.order_third, got.order_third);
            fail_count++;
        end
        if (got.order_fourth !== want.order_fourth) begin
            $error("order_fourth mismatch: expected %0d, got %0d",
                   want.order_fourth, got.order_fourth);
            fail_count++;
        end
    endtask

    task automatic send_net(input t_pins net, input int gap, input bit typed,
                            input t_result typed_want);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_pins <= net;
        do @(posedge i_clk); while (o_busy);
        expect_word(typed ? typed_want : steiner_predict(net, style_now));
        nets_sent++;
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        i_start <= 1'b0;
        while (pending_results.size() != 0 && waited < 200) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    task automatic write_tree_style(input bit style);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= style;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        style_now = style;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("result word with no net pending");
                fail_count++;
            end else begin
                check_result(pending_results.pop_front(), o_result);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("four_pin_steiner_classifier_top_tb NOT OK");
        $finish;
    end

    initial begin
        t_result plain_zero;
        bit      no_gaps;
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_pins      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 1'b0;
        style_now = STYLE_FLEXIBLE;

        // no shape: zero points, y order with ties kept in pin order
        plain_zero = t_result'{KIND_NONE, 16'd0, 16'd0, 16'd0, 16'd0, 2'd0, 2'd1, 2'd2, 2'd3};
        add_row(pins_of(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, plain_zero);
        add_row(pins_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1, plain_zero);
        add_row(pins_of(0, 0, 10, 20, 20, 30, 30, 5), 1'b0, '0);
        add_row(pins_of(5, 40, 15, 10, 25, 12, 35, 50), 1'b0, '0);
        add_row(pins_of(50, 30, 2, 0, 60, 10, 1, 40), 1'b0, '0);
        add_row(pins_of(10, 0, 0, 5, 3, 9, 12, 20), 1'b0, '0);
        add_row(pins_of(0, 1, 1, 2, 2, 3, 3, 0), 1'b0, '0);
        add_row(pins_of(0, 0, 1, 16'hFFFF, 16'hFFFE, 16'hFFFF, 16'hFFFF, 0), 1'b0, '0);
        add_row(pins_of(16'hFFFE, 16'hFFFF, 1, 16'hFFFE, 0, 1, 16'hFFFF, 0), 1'b0, '0);
        add_row(pins_of(5, 0, 5, 10, 9, 10, 12, 0), 1'b0, '0);
        add_row(pins_of(0, 0, 10, 5, 20, 9, 30, 5), 1'b0, '0);
        add_row(pins_of(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'h5555,
                        16'h5555, 16'hAAAA, 16'hAAAA), 1'b0, '0);
        add_row(pins_of(30, 5, 20, 30, 10, 20, 0, 0), 1'b0, '0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int pass = 0; pass < 2; pass++) begin
            if (pass == 1) write_tree_style(STYLE_UNFLEXIBLE);
            foreach (net_rows[r]) begin
                send_net(net_rows[r].pins, idle_gap(), net_rows[r].typed, net_rows[r].want);
                directed_sent++;
            end
        end

        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 0) write_tree_style(STYLE_FLEXIBLE);
            else if (phase == 1) write_tree_style(STYLE_UNFLEXIBLE);
            else write_tree_style($urandom_range(0, 1));
            no_gaps = ($urandom_range(0, 2) == 0);
            for (int n = 0; n < 158; n++)
                send_net(random_net(), no_gaps ? 0 : idle_gap(), 1'b0, '0);
        end

        drain_results();
        repeat (6) @(posedge i_clk);
        while (pending_results.size() != 0) begin
            void'(pending_results.pop_front());
            $error("net never produced its result word");
            fail_count++;
        end

        $display("sent %0d nets (%0d directed) under both tree styles, checked %0d words",
                 nets_sent, directed_sent, results_checked);
        $display("kinds seen: none %0d, x high %0d, x low %0d, y right %0d, y left %0d",
                 kind_seen[KIND_NONE], kind_seen[KIND_X_HIGH], kind_seen[KIND_X_LOW],
                 kind_seen[KIND_Y_RIGHT], kind_seen[KIND_Y_LEFT]);
        if (fail_count == 0) begin
            $display("four_pin_steiner_classifier_top_tb OK");
        end else begin
            $display("four_pin_steiner_classifier_top_tb NOT OK");
        end
        $finish;
    end

endmodule

FILE: four_pin_steiner_classifier_top.f
+incdir+src
src/fpsc_pkg.sv
src/fpsc_lane.sv
src/fpsc_merge.sv
src/four_pin_steiner_classifier_top.sv
test/four_pin_steiner_classifier_top_tb.sv
